@@ design/plq_pkg.sv @@
// Package for the price-level order queue: payload structs, op and status
// codes, sizing constants and the controller command struct. No dependencies.
`timescale 1ns / 1ps

package plq_pkg;

    // Queue depth and the widths that follow from it.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths.
    localparam int OP_W      = 2;
    localparam int WORD_W    = 32;
    localparam int TOTAL_W   = 38;
    localparam int STATUS_W  = 3;
    localparam int ORD_CNT_W = 7;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD          = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_ID    = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY        = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] order_id;
        logic [WORD_W-1:0] order_price;
        logic [WORD_W-1:0] order_quantity;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [WORD_W-1:0]    front_id;
        logic [WORD_W-1:0]    front_quantity;
        logic [TOTAL_W-1:0]   total_quantity;
        logic [ORD_CNT_W-1:0] order_count;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_req;  // capture the incoming request
        logic search;    // evaluate the match row, latch select/shift masks
        logic commit;    // apply the update and load the result register
    } t_ctl_cmd;

endpackage

@@ design/price_level_order_queue.sv @@
// Top level of the price-level order queue: controller plus datapath.
// Depends on plq_pkg, plq_ctrl and plq_datapath.
`timescale 1ns / 1ps

// One price level of an order book: a FIFO of up to CAPACITY (64) resting
// orders, all at the price in the level_price register. Each request is one
// op: add at the back, remove the front, remove the oldest order with a given
// id, or query. Every request returns one result: status plus the front
// order, total remaining quantity and count as they stand after the op.
// Sequence: each request passes through a search state, in which all cells
// compare their id against the request in parallel and latch a one-hot
// select, then a commit state that shifts the cells above the removed one
// down, updates count and total and loads the result register. The next
// request is taken in the commit cycle, so a new request can enter while the
// last one commits; a stalled result holds the commit until the result
// register frees. Write level_price only while idle.
module price_level_order_queue import plq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: level_price
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_wdata,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_req              i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_rsp              o_out_data
);

    t_ctl_cmd cmd;

    // Sequencing: accept, search, commit; owns result valid.
    plq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Order cells, count, total and result register.
    plq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_out_data  (o_out_data)
    );

endmodule

@@ design/plq_ctrl.sv @@
// Controller for the price-level order queue: accept / search / commit
// sequencing and result-register valid. Depends on plq_pkg.
`timescale 1ns / 1ps

module plq_ctrl import plq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_ctl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       commit;
    logic       accept;

    // Result register can take a new result this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = (r_state == S_COMMIT) && out_free;
    // A new request enters while idle or alongside a commit.
    assign o_in_stall = !((r_state == S_IDLE) || commit);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit) n_state = accept ? S_SEARCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit)            n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cmd.load_req = accept;
    assign o_cmd.search   = (r_state == S_SEARCH);
    assign o_cmd.commit   = commit;

    // A commit always leaves a result pending.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("commit did not raise result valid");

    // Search is always followed by a commit attempt.
    a_search_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.search |=> (r_state == S_COMMIT))
        else $error("search not followed by commit state");

endmodule

@@ design/plq_datapath.sv @@
// Datapath for the price-level order queue: request register, row of order
// cells with parallel id compare, count/total, result register. Uses plq_pkg.
`timescale 1ns / 1ps

module plq_datapath import plq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_wdata,
    input  t_req              i_in_data,
    input  t_ctl_cmd          i_cmd,
    output t_rsp              o_out_data
);

    t_req               r_req;
    logic [WORD_W-1:0]  r_level_price;

    logic [WORD_W-1:0]  r_ids [CAPACITY];
    logic [WORD_W-1:0]  r_qty [CAPACITY];
    logic [WORD_W-1:0]  n_ids [CAPACITY];
    logic [WORD_W-1:0]  n_qty [CAPACITY];

    logic [CNT_W-1:0]   r_count, n_count;
    logic [TOTAL_W-1:0] r_total, n_total;

    logic [CAPACITY-1:0] r_first, r_shift;
    logic                r_found;

    logic [CAPACITY-1:0] match, cand, cand_m1;
    logic [WORD_W-1:0]   removed_qty;
    logic [STATUS_W-1:0] status;
    logic                do_add, do_remove;
    t_rsp                r_rsp, n_rsp;

    // Search: candidate row, then lowest set bit and cells at or above it.
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            match[k] = (r_ids[k] == r_req.order_id) && (CNT_W'(k) < r_count);
        end
        cand = '0;
        if (r_req.op == OP_REMOVE_FRONT) cand[0] = (r_count != '0);
        else if (r_req.op == OP_REMOVE_ID) cand = match;
        cand_m1 = cand - CAPACITY'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_first <= cand & ~cand_m1;
            r_shift <= (cand != '0) ? ~(~cand & cand_m1) : '0;
            r_found <= (cand != '0);
        end
        if (i_cmd.load_req) r_req <= i_in_data;
    end

    // Commit: decide, shift or append, update count and total.
    always_comb begin
        removed_qty = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (r_first[k]) removed_qty = removed_qty | r_qty[k];
        end

        do_add    = 1'b0;
        do_remove = 1'b0;
        status    = ST_OK;
        unique case (r_req.op)
            OP_ADD: begin
                if (r_req.order_price != r_level_price) status = ST_MISMATCH;
                else if (r_count == CNT_W'(CAPACITY))  status = ST_FULL;
                else                                    do_add = 1'b1;
            end
            OP_REMOVE_FRONT: begin
                if (r_found) do_remove = 1'b1;
                else         status    = ST_EMPTY;
            end
            OP_REMOVE_ID: begin
                if (r_found) do_remove = 1'b1;
                else         status    = ST_NOT_FOUND;
            end
            OP_QUERY: begin
                status = ST_OK;
            end
            default: begin
                status = ST_OK;
            end
        endcase

        for (int k = 0; k < CAPACITY; k++) begin
            n_ids[k] = r_ids[k];
            n_qty[k] = r_qty[k];
        end
        if (do_remove) begin
            for (int k = 0; k < CAPACITY - 1; k++) begin
                if (r_shift[k]) begin
                    n_ids[k] = r_ids[k+1];
                    n_qty[k] = r_qty[k+1];
                end
            end
        end
        if (do_add) begin
            for (int k = 0; k < CAPACITY; k++) begin
                if (CNT_W'(k) == r_count) begin
                    n_ids[k] = r_req.order_id;
                    n_qty[k] = r_req.order_quantity;
                end
            end
        end

        n_count = r_count;
        n_total = r_total;
        if (do_add) begin
            n_count = r_count + CNT_W'(1);
            n_total = r_total + TOTAL_W'(r_req.order_quantity);
        end else if (do_remove) begin
            n_count = r_count - CNT_W'(1);
            n_total = r_total - TOTAL_W'(removed_qty);
        end

        n_rsp.status         = status;
        n_rsp.front_id       = (n_count != '0) ? n_ids[0] : '0;
        n_rsp.front_quantity = (n_count != '0) ? n_qty[0] : '0;
        n_rsp.total_quantity = n_total;
        n_rsp.order_count    = ORD_CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_total       <= '0;
            r_level_price <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_count <= n_count;
                r_total <= n_total;
            end
            if (i_cfg_we) r_level_price <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int k = 0; k < CAPACITY; k++) begin
                r_ids[k] <= n_ids[k];
                r_qty[k] <= n_qty[k];
            end
            r_rsp <= n_rsp;
        end
    end

    assign o_out_data = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("order count above capacity");

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.search) |-> ($onehot0(r_first) && (r_found == (r_first != '0))))
        else $error("select mask not one-hot or found flag mismatched");

    a_shift_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.search) |-> ((r_first & ~r_shift) == '0))
        else $error("shift mask does not include the selected cell");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for price_level_order_queue: a random and directed
// order stream, a predictor of the price level, result checks. Depends on plq_pkg.
`timescale 1ns / 1ps

module testbench;
    import plq_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 20;
    localparam logic [WORD_W-1:0] WORD_MAX = '1;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [WORD_W-1:0] i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_req              i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_rsp              o_out_data;

    price_level_order_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Orders waiting to be offered, and results predicted but not yet seen.
    t_req order_feed[$];
    t_rsp expected_rsps[$];
    t_rsp want_rsp;

    // Idle rates in percent, and long result hold-off requests.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int mismatches    = 0;

    // Shadow of the price level.
    logic [WORD_W-1:0]  level_price_model = '0;
    logic [WORD_W-1:0]  rest_ids [CAPACITY];
    logic [WORD_W-1:0]  rest_qty [CAPACITY];
    int                 rest_count = 0;
    logic [TOTAL_W-1:0] rest_total = '0;

    // Take the order at slot pos out and close the gap behind it.
    function automatic void drop_resting(input int pos);
        rest_total = rest_total - TOTAL_W'(rest_qty[pos]);
        for (int k = pos; k + 1 < rest_count; k++) begin
            rest_ids[k] = rest_ids[k + 1];
            rest_qty[k] = rest_qty[k + 1];
        end
        rest_count--;
    endfunction

    // Apply one request to the shadow book and return the result it yields.
    function automatic t_rsp book_step(input t_req r);
        t_rsp rsp;
        int   hit;
        rsp        = '0;
        rsp.status = ST_OK;
        hit        = -1;
        case (r.op)
            OP_ADD: begin
                if (r.order_price != level_price_model) begin
                    rsp.status = ST_MISMATCH;
                end else if (rest_count >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    rest_ids[rest_count] = r.order_id;
                    rest_qty[rest_count] = r.order_quantity;
                    rest_count++;
                    rest_total = rest_total + TOTAL_W'(r.order_quantity);
                end
            end
            OP_REMOVE_FRONT: begin
                if (rest_count == 0) rsp.status = ST_EMPTY;
                else drop_resting(0);
            end
            OP_REMOVE_ID: begin
                // oldest match wins when ids repeat
                for (int k = 0; k < rest_count && hit < 0; k++)
                    if (rest_ids[k] == r.order_id) hit = k;
                if (hit < 0) rsp.status = ST_NOT_FOUND;
                else drop_resting(hit);
            end
            default: ;
        endcase
        rsp.front_id       = (rest_count != 0) ? rest_ids[0] : '0;
        rsp.front_quantity = (rest_count != 0) ? rest_qty[0] : '0;
        rsp.total_quantity = rest_total;
        rsp.order_count    = ORD_CNT_W'(rest_count);
        return rsp;
    endfunction

    function automatic bit field_ok(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Request driver: a held request never changes until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) expected_rsps = {expected_rsps, book_step(i_in_data)};
            if (order_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_data  <= order_feed[0];
                order_feed.delete(0);
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    $error("result with nothing pending: 0x%0h", o_out_data);
                    mismatches++;
                end else begin
                    want_rsp = expected_rsps[0];
                    expected_rsps.delete(0);
                    if (!(field_ok("status", want_rsp.status, o_out_data.status)
                        & field_ok("front_id", want_rsp.front_id, o_out_data.front_id)
                        & field_ok("front_quantity", want_rsp.front_quantity,
                                   o_out_data.front_quantity)
                        & field_ok("total_quantity", want_rsp.total_quantity,
                                   o_out_data.total_quantity)
                        & field_ok("order_count", want_rsp.order_count,
                                   o_out_data.order_count)))
                        mismatches++;
                end
            end
            if (hold_served != hold_requests) begin
                hold_served <= hold_requests;
                hold_left   <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    task automatic push_order(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] id,
                              input logic [WORD_W-1:0] price,
                              input logic [WORD_W-1:0] qty);
        t_req r;
        r.op             = op;
        r.order_id       = id;
        r.order_price    = price;
        r.order_quantity = qty;
        order_feed = {order_feed, r};
    endtask

    // Polled at the falling edge so the driver and monitor have settled.
    task automatic wait_book_idle();
        do @(negedge i_clk);
        while (order_feed.size() != 0 || i_in_valid || expected_rsps.size() != 0);
    endtask

    task automatic set_level_price(input logic [WORD_W-1:0] price);
        wait_book_idle();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= price;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        level_price_model = price;
        @(negedge i_clk);
    endtask

    // Runs of requests biased toward filling, draining or churning the level,
    // plus pure noise. A small id pool keeps removals by id hitting and
    // makes duplicate ids common.
    task automatic queue_random_orders(input int n);
        int   mode;
        int   run;
        int   pick;
        t_req r;
        while (n > 0) begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(8, 90);
            for (int k = 0; k < run && n > 0; k++) begin
                pick             = $urandom_range(0, 99);
                r.order_id       = ($urandom_range(0, 9) == 0) ? $urandom()
                                                               : $urandom_range(0, 15);
                r.order_price    = level_price_model;
                r.order_quantity = $urandom();
                if ($urandom_range(0, 7) == 0)
                    r.order_quantity = $urandom_range(0, 1) ? WORD_MAX : '0;
                if ($urandom_range(0, 11) == 0)
                    r.order_price = $urandom_range(0, 1) ? $urandom()
                        : level_price_model ^ (32'd1 << $urandom_range(0, 31));
                case (mode)
                    0: r.op = (pick < 85) ? OP_ADD : (pick < 92) ? OP_QUERY : OP_REMOVE_ID;
                    1: r.op = (pick < 45) ? OP_REMOVE_FRONT : (pick < 80) ? OP_REMOVE_ID
                            : (pick < 90) ? OP_ADD : OP_QUERY;
                    2: r.op = OP_W'($urandom_range(0, 3));
                    default: begin
                        r.op             = OP_W'($urandom_range(0, 3));
                        r.order_id       = $urandom();
                        r.order_price    = $urandom();
                        r.order_quantity = $urandom();
                    end
                endcase
                order_feed = {order_feed, r};
                n--;
            end
        end
    endtask

    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pass at the reset price of zero.
        send_idle_pct = 26;
        recv_idle_pct = 66;
        push_order(OP_QUERY, $urandom(), $urandom(), $urandom());
        push_order(OP_REMOVE_FRONT, WORD_MAX, WORD_MAX, WORD_MAX);
        push_order(OP_REMOVE_ID, 32'd0, 32'd0, 32'd0);
        push_order(OP_ADD, 32'd1, 32'd1, 32'd1);
        push_order(OP_ADD, WORD_MAX, 32'd0, WORD_MAX);
        push_order(OP_ADD, 32'd0, 32'd0, 32'd0);
        push_order(OP_ADD, 32'd5, 32'd0, 32'd7);
        push_order(OP_ADD, 32'd5, 32'd0, 32'd9);
        push_order(OP_REMOVE_ID, 32'd5, $urandom(), $urandom());
        push_order(OP_QUERY, 32'd0, 32'd0, 32'd0);
        push_order(OP_REMOVE_ID, 32'd1234, 32'd0, 32'd0);
        push_order(OP_REMOVE_ID, WORD_MAX, 32'd0, 32'd0);
        push_order(OP_ADD, 32'hA5A5_A5A5, WORD_MAX, 32'd3);
        push_order(OP_REMOVE_FRONT, 32'd0, 32'd0, 32'd0);
        push_order(OP_REMOVE_FRONT, $urandom(), $urandom(), $urandom());
        push_order(OP_REMOVE_FRONT, 32'd0, 32'd0, 32'd0);
        push_order(OP_QUERY, WORD_MAX, WORD_MAX, WORD_MAX);

        // Top price; fill to capacity at max quantity, then poke the full level.
        set_level_price(WORD_MAX);
        for (int k = 0; k < CAPACITY + 4; k++)
            push_order(OP_ADD, $urandom_range(0, 15), WORD_MAX, WORD_MAX);
        push_order(OP_ADD, 32'd3, 32'd0, 32'd1);
        push_order(OP_QUERY, 32'd0, 32'd0, 32'd0);
        queue_random_orders(250);
        hold_requests++;
        wait_book_idle();
        queue_random_orders(230);

        // Random price, idle rates swapped; sender drains mid-phase.
        set_level_price($urandom());
        send_idle_pct = 66;
        recv_idle_pct = 26;
        queue_random_orders(280);
        wait_book_idle();
        queue_random_orders(280);

        // Zero price, back to back.
        set_level_price('0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_orders(300);
        hold_requests++;
        queue_random_orders(300);

        wait_book_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
